/* rtl/core/local_interrupt_timer_registers_assert.svh */
// Assertion macros used by the checker module of the timer block.
// Each macro takes a label, a property body and a message string.
`ifndef LOCAL_INTERRUPT_TIMER_REGISTERS_ASSERT_SVH
`define LOCAL_INTERRUPT_TIMER_REGISTERS_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define LIT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define LIT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/lit_pkg.sv */
// Shared constants, types and helper functions of the local interrupt timer.
// No dependencies; used by lit_timer, lit_csr and the top level.
`default_nettype none

package lit_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 32;

   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_WRITE = 2'd2;

   localparam logic [9:0] OFS_ID   = 10'h020;
   localparam logic [9:0] OFS_EOI  = 10'h0B0;
   localparam logic [9:0] OFS_SVR  = 10'h0F0;
   localparam logic [9:0] OFS_LVT  = 10'h320;
   localparam logic [9:0] OFS_INIT = 10'h380;
   localparam logic [9:0] OFS_CURR = 10'h390;
   localparam logic [9:0] OFS_DIV  = 10'h3E0;

   localparam int SVR_ENABLE_BIT   = 8;
   localparam int LVT_MASK_BIT     = 16;
   localparam int LVT_PERIODIC_BIT = 17;

   localparam logic [7:0] SVR_VECTOR_RESET = 8'hFF;
   localparam logic [2:0] DIV_CODE_ONE     = 3'd7;

   typedef struct packed {
      logic tick;
      logic load;
   } timer_op_type;

   typedef struct packed {
      logic       periodic;
      logic [2:0] divide;
   } timer_cfg_type;

   function automatic logic [7:0] divisor_of(input logic [2:0] code);
      logic [7:0] result;
      if (code == DIV_CODE_ONE) begin
         result = 8'd1;
      end else begin
         result = 8'd2 << code;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/lit_timer.sv */
// Prescaler and down-counter of the local interrupt timer.
// Depends on lit_pkg for the divide decode and the control structs.
`default_nettype none

module lit_timer #(
   parameter int COUNT_WIDTH = lit_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire lit_pkg::timer_op_type    op,
   input  wire lit_pkg::timer_cfg_type   cfg,
   input  wire logic [COUNT_WIDTH-1:0]   load_value,
   output logic      [COUNT_WIDTH-1:0]   current_count,
   output logic      [COUNT_WIDTH-1:0]   initial_count,
   output logic                          expire
);

   logic [COUNT_WIDTH-1:0] current_count_ff, current_count_in;
   logic [COUNT_WIDTH-1:0] initial_count_ff, initial_count_in;
   logic [6:0]             prescale_ff, prescale_in;
   logic [COUNT_WIDTH-1:0] count_dec;
   logic [7:0]             prescale_next;
   logic                   running;
   logic                   wrap;

   assign running       = current_count_ff != '0;
   assign prescale_next = {1'b0, prescale_ff} + 8'd1;
   assign wrap          = prescale_next >= lit_pkg::divisor_of(cfg.divide);
   assign count_dec     = current_count_ff - COUNT_WIDTH'(1);
   assign expire        = op.tick && running && wrap && (count_dec == '0);

   always_comb begin
      current_count_in = current_count_ff;
      initial_count_in = initial_count_ff;
      prescale_in      = prescale_ff;
      if (op.load) begin
         initial_count_in = load_value;
         current_count_in = load_value;
         prescale_in      = '0;
      end else if (op.tick && running) begin
         if (!wrap) begin
            prescale_in = prescale_next[6:0];
         end else begin
            prescale_in = '0;
            if (count_dec == '0 && cfg.periodic) begin
               current_count_in = initial_count_ff;
            end else begin
               current_count_in = count_dec;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_count_ff <= '0;
         initial_count_ff <= '0;
         prescale_ff      <= '0;
      end else begin
         current_count_ff <= current_count_in;
         initial_count_ff <= initial_count_in;
         prescale_ff      <= prescale_in;
      end
   end

   assign current_count = current_count_ff;
   assign initial_count = initial_count_ff;

endmodule

`default_nettype wire

/* rtl/core/lit_csr.sv */
// Register file, decode and read mux of the local interrupt timer.
// Depends on lit_pkg; drives the timer control structs for lit_timer.
`default_nettype none

module lit_csr #(
   parameter int COUNT_WIDTH = lit_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_write_enable,
   input  wire logic [7:0]               csr_write_data,
   input  wire logic                     item_go,
   input  wire logic [1:0]               mode,
   input  wire logic [9:0]               offset,
   input  wire logic [31:0]              write_data,
   input  wire logic [COUNT_WIDTH-1:0]   current_count,
   input  wire logic [COUNT_WIDTH-1:0]   initial_count,
   input  wire logic                     expire,
   output lit_pkg::timer_op_type         op,
   output lit_pkg::timer_cfg_type        cfg,
   output logic      [COUNT_WIDTH-1:0]   load_value,
   output logic      [31:0]              read_data,
   output logic                          irq_fire,
   output logic      [7:0]               irq_vector
);

   logic [7:0] apic_id_ff;
   logic [7:0] spurious_vector_ff, spurious_vector_in;
   logic       soft_enable_ff, soft_enable_in;
   logic [7:0] timer_vector_ff, timer_vector_in;
   logic       timer_masked_ff, timer_masked_in;
   logic       timer_periodic_ff, timer_periodic_in;
   logic [2:0] divide_ff, divide_in;
   logic       is_write;

   assign is_write   = item_go && (mode == lit_pkg::MODE_WRITE);
   assign op.tick    = item_go && (mode == lit_pkg::MODE_TICK);
   assign op.load    = is_write && (offset == lit_pkg::OFS_INIT);
   assign load_value = write_data[COUNT_WIDTH-1:0];
   assign cfg.periodic = timer_periodic_ff;
   assign cfg.divide   = divide_ff;

   always_comb begin
      spurious_vector_in = spurious_vector_ff;
      soft_enable_in     = soft_enable_ff;
      timer_vector_in    = timer_vector_ff;
      timer_masked_in    = timer_masked_ff;
      timer_periodic_in  = timer_periodic_ff;
      divide_in          = divide_ff;
      if (is_write) begin
         unique case (offset)
            lit_pkg::OFS_SVR: begin
               spurious_vector_in = write_data[7:0];
               soft_enable_in     = write_data[lit_pkg::SVR_ENABLE_BIT];
            end
            lit_pkg::OFS_LVT: begin
               timer_vector_in   = write_data[7:0];
               timer_masked_in   = write_data[lit_pkg::LVT_MASK_BIT];
               timer_periodic_in = write_data[lit_pkg::LVT_PERIODIC_BIT];
            end
            lit_pkg::OFS_DIV: begin
               divide_in = {write_data[3], write_data[1:0]};
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      read_data = '0;
      if (item_go && mode == lit_pkg::MODE_READ) begin
         unique case (offset)
            lit_pkg::OFS_ID:   read_data = {apic_id_ff, 24'd0};
            lit_pkg::OFS_SVR:  read_data = {23'd0, soft_enable_ff, spurious_vector_ff};
            lit_pkg::OFS_LVT:  read_data = {14'd0, timer_periodic_ff, timer_masked_ff,
                                            8'd0, timer_vector_ff};
            lit_pkg::OFS_INIT: read_data = 32'(initial_count);
            lit_pkg::OFS_CURR: read_data = 32'(current_count);
            lit_pkg::OFS_DIV:  read_data = {28'd0, divide_ff[2], 1'b0, divide_ff[1:0]};
            default:           read_data = '0;
         endcase
      end
   end

   assign irq_fire   = expire && soft_enable_ff && !timer_masked_ff;
   assign irq_vector = irq_fire ? timer_vector_ff : 8'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         apic_id_ff         <= '0;
         spurious_vector_ff <= lit_pkg::SVR_VECTOR_RESET;
         soft_enable_ff     <= 1'b0;
         timer_vector_ff    <= '0;
         timer_masked_ff    <= 1'b1;
         timer_periodic_ff  <= 1'b0;
         divide_ff          <= '0;
      end else begin
         if (csr_write_enable) begin
            apic_id_ff <= csr_write_data;
         end
         spurious_vector_ff <= spurious_vector_in;
         soft_enable_ff     <= soft_enable_in;
         timer_vector_ff    <= timer_vector_in;
         timer_masked_ff    <= timer_masked_in;
         timer_periodic_ff  <= timer_periodic_in;
         divide_ff          <= divide_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/local_interrupt_timer_registers.sv */
// Top level of the local interrupt timer: input register, register file,
// timer core and result register. Depends on lit_pkg, lit_csr, lit_timer.
//
//   channel  prefix  direction  handshake
//   request  req_    in         req_valid / req_stall
//   response rsp_    out        rsp_valid / rsp_stall
//   config   csr_    in         csr_write_enable, no back-pressure
//
// An item is registered in the input register and is executed as it moves
// into the result register, which drives rsp_valid.
// One item per cycle is sustained; the whole path stalls while a result is
// held by rsp_stall. Reset is synchronous and clears valid bits and all
// timer and register state; no clearing pass is needed.
`default_nettype none

module local_interrupt_timer_registers #(
   parameter int COUNT_WIDTH = lit_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [7:0]  csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_mode,
   input  wire logic [9:0]  req_offset,
   input  wire logic [31:0] req_write_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_read_data,
   output logic             rsp_irq_fire,
   output logic [7:0]       rsp_irq_vector
);

   logic                   in_valid_ff;
   logic [1:0]             in_mode_ff;
   logic [9:0]             in_offset_ff;
   logic [31:0]            in_write_data_ff;
   logic                   out_valid_ff;
   logic [31:0]            out_read_data_ff;
   logic                   out_irq_fire_ff;
   logic [7:0]             out_irq_vector_ff;
   logic                   advance;
   logic                   item_go;
   lit_pkg::timer_op_type  op;
   lit_pkg::timer_cfg_type cfg;
   logic [COUNT_WIDTH-1:0] load_value;
   logic [COUNT_WIDTH-1:0] current_count;
   logic [COUNT_WIDTH-1:0] initial_count;
   logic                   expire;
   logic [31:0]            read_data;
   logic                   irq_fire;
   logic [7:0]             irq_vector;

   assign advance   = !(out_valid_ff && rsp_stall);
   assign item_go   = in_valid_ff && advance;
   assign req_stall = !advance;

   lit_csr #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .item_go          (item_go),
      .mode             (in_mode_ff),
      .offset           (in_offset_ff),
      .write_data       (in_write_data_ff),
      .current_count    (current_count),
      .initial_count    (initial_count),
      .expire           (expire),
      .op               (op),
      .cfg              (cfg),
      .load_value       (load_value),
      .read_data        (read_data),
      .irq_fire         (irq_fire),
      .irq_vector       (irq_vector)
   );

   lit_timer #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_timer (
      .clock         (clock),
      .reset         (reset),
      .op            (op),
      .cfg           (cfg),
      .load_value    (load_value),
      .current_count (current_count),
      .initial_count (initial_count),
      .expire        (expire)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff  <= req_valid;
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_mode_ff        <= req_mode;
         in_offset_ff      <= req_offset;
         in_write_data_ff  <= req_write_data;
         out_read_data_ff  <= read_data;
         out_irq_fire_ff   <= irq_fire;
         out_irq_vector_ff <= irq_vector;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_read_data  = out_read_data_ff;
   assign rsp_irq_fire   = out_irq_fire_ff;
   assign rsp_irq_vector = out_irq_vector_ff;

endmodule

`default_nettype wire

/* rtl/core/lit_checker.sv */
// Port-level checker for the local interrupt timer, bound to the top level.
// Depends on local_interrupt_timer_registers_assert.svh for its macros.
`default_nettype none

`include "local_interrupt_timer_registers_assert.svh"

module lit_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_read_data,
   input wire logic        rsp_irq_fire,
   input wire logic [7:0]  rsp_irq_vector
);

   `LIT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_read_data) && $stable(rsp_irq_fire) && $stable(rsp_irq_vector), "stalled item changed")
   `LIT_ASSERT_NOW(a_backpressure, rsp_valid && rsp_stall, req_stall, "input taken while output is stalled")
   `LIT_ASSERT_NOW(a_vector_idle, rsp_valid && !rsp_irq_fire, rsp_irq_vector == 8'd0, "vector without interrupt")
   `LIT_ASSERT_NOW(a_fire_no_read, rsp_valid && rsp_irq_fire, rsp_read_data == 32'd0, "interrupt item carries read data")

endmodule

bind local_interrupt_timer_registers lit_checker u_lit_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_read_data  (rsp_read_data),
   .rsp_irq_fire   (rsp_irq_fire),
   .rsp_irq_vector (rsp_irq_vector)
);

`default_nettype wire
